// ===== hw/rtl/wqc_pkg.sv =====
// Wait queue with cancel: shared field widths, command and status codes,
// and the control struct that drives the cell chain. No dependencies.
package wqc_pkg;

  // Fixed field widths of the channel payloads
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned TID_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // Per-cycle control broadcast to every cell
  typedef struct packed {
    logic shift;  // every cell not being loaded takes its right neighbor's entry
    logic load;   // the cell at the write index takes the load data
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/wqc_if.sv =====
// Wait queue with cancel: command and result channel interfaces.
// Depends on wqc_pkg for the payload widths.
interface wqc_in_if import wqc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [TID_W-1:0] thread_id;

  modport source (output valid, output cmd, output thread_id, input ready);
  modport sink   (input valid, input cmd, input thread_id, output ready);
endinterface

interface wqc_out_if import wqc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TID_W-1:0]    thread_out;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output status, output thread_out, output occupancy,
                  input ready);
  modport sink   (input valid, input status, input thread_out, input occupancy,
                  output ready);
endinterface

// ===== hw/rtl/wait_queue_with_cancel_top.sv =====
// Wait queue with cancel: FIFO of thread identifiers kept packed in a chain of cells.
// Add and remove give their result in the cycle after the transfer; one command per cycle
// while no cancel runs and the result channel is free. Cancel rotates the queue through the
// head, one entry per cycle, dropping matches; its result is registered once every queued entry is done.
// Reset (rst_ni low, asynchronous) empties the queue and drops any pending result;
// the result fields and slot contents are not cleared.
module wait_queue_with_cancel_top import wqc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  wqc_in_if.sink    in_ch,
  wqc_out_if.source out_ch
);

  localparam int unsigned IdxW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {S_IDLE, S_CANCEL} state_e;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     remain_q, remain_d;
  logic [ID_WIDTH-1:0] id_q, id_d;
  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [TID_W-1:0]    thread_out_q, thread_out_d;
  logic [OCC_W-1:0]    occ_q, occ_d;

  cell_ctrl_t          ctrl;
  logic [IdxW-1:0]     wr_idx;
  logic [ID_WIDTH-1:0] load_data;
  logic [ID_WIDTH-1:0] id_in;
  logic [ID_WIDTH-1:0] cell_data [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0] head;
  logic                out_free;
  logic                in_fire;
  logic                keep;

  // Build the chain; the last cell shifts in its own entry
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_WIDTH-1:0] right;
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_mid
      assign right = cell_data[i+1];
    end
    wqc_cell #(
      .IdxW   (IdxW),
      .IdW    (ID_WIDTH),
      .CellIx (i)
    ) u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .wr_idx_i     (wr_idx),
      .load_data_i  (load_data),
      .right_data_i (right),
      .data_o       (cell_data[i])
    );
  end

  assign head     = cell_data[0];
  assign id_in    = ID_WIDTH'(in_ch.thread_id);
  assign out_free = !out_valid_q || out_ch.ready;
  assign in_ch.ready = (state_q == S_IDLE) && out_free;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign keep     = (head != id_q);

  // Command decode and cancel rotation
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    remain_d     = remain_q;
    id_d         = id_q;
    out_valid_d  = out_valid_q && !out_ch.ready;
    status_d     = status_q;
    thread_out_d = thread_out_q;
    occ_d        = occ_q;
    ctrl.shift   = 1'b0;
    ctrl.load    = 1'b0;
    wr_idx       = IdxW'(count_q);
    load_data    = id_in;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          out_valid_d  = 1'b1;
          status_d     = STATUS_OK;
          thread_out_d = '0;
          occ_d        = OCC_W'(count_q);
          case (in_ch.cmd)
            CMD_ADD: begin
              if (count_q >= CntW'(QUEUE_DEPTH)) begin
                status_d = STATUS_FULL;
              end else begin
                ctrl.load = 1'b1;
                count_d   = count_q + 1'b1;
                occ_d     = OCC_W'(count_q + 1'b1);
              end
            end
            CMD_REMOVE: begin
              if (count_q == '0) begin
                status_d = STATUS_EMPTY;
              end else begin
                ctrl.shift   = 1'b1;
                thread_out_d = TID_W'(head);
                count_d      = count_q - 1'b1;
                occ_d        = OCC_W'(count_q - 1'b1);
              end
            end
            CMD_CANCEL: begin
              if (count_q != '0) begin
                out_valid_d = 1'b0;
                id_d        = id_in;
                remain_d    = count_q;
                state_d     = S_CANCEL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CANCEL: begin
        if (remain_q != '0) begin
          // Pop the head, re-append it at the tail unless it matches
          ctrl.shift = 1'b1;
          ctrl.load  = keep;
          wr_idx     = IdxW'(count_q - 1'b1);
          load_data  = head;
          remain_d   = remain_q - 1'b1;
          if (!keep) begin
            count_d = count_q - 1'b1;
          end
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          status_d     = STATUS_OK;
          thread_out_d = '0;
          occ_d        = OCC_W'(count_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Hold state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q         <= id_d;
    status_q     <= status_d;
    thread_out_q <= thread_out_d;
    occ_q        <= occ_d;
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.status     = status_q;
  assign out_ch.thread_out = thread_out_q;
  assign out_ch.occupancy  = occ_q;

endmodule

// ===== hw/rtl/wqc_cell.sv =====
// Wait queue with cancel: one slot of the queue chain.
// Depends on wqc_pkg for the control struct.
module wqc_cell import wqc_pkg::*; #(
  parameter int unsigned IdxW   = 4,
  parameter int unsigned IdW    = 16,
  parameter int unsigned CellIx = 0
) (
  input  logic             clk_i,
  input  cell_ctrl_t       ctrl_i,
  input  logic [IdxW-1:0]  wr_idx_i,
  input  logic [IdW-1:0]   load_data_i,
  input  logic [IdW-1:0]   right_data_i,
  output logic [IdW-1:0]   data_o
);

  logic [IdW-1:0] data_q;
  logic [IdW-1:0] data_d;
  logic           hit;

  // Select this slot for a load
  assign hit = ctrl_i.load && (wr_idx_i == IdxW'(CellIx));

  // Load wins over the shift from the right neighbor
  always_comb begin
    data_d = data_q;
    if (hit) begin
      data_d = load_data_i;
    end else if (ctrl_i.shift) begin
      data_d = right_data_i;
    end
  end

  // Hold the entry; contents need no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== hw/rtl/wqc_checker.sv =====
// Wait queue with cancel: port-level checks on the result channel.
// Depends on wqc_pkg; bound to wait_queue_with_cancel_top below.
module wqc_checker import wqc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_i,
  input logic                out_ready_i,
  input logic [STATUS_W-1:0] status_i,
  input logic [TID_W-1:0]    thread_out_i,
  input logic [OCC_W-1:0]    occupancy_i
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(thread_out_i) && $stable(occupancy_i))
    else $error("result changed while stalled");

  // Refused add only happens on a full queue
  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STATUS_FULL |-> occupancy_i == OCC_W'(QUEUE_DEPTH))
    else $error("full status with queue not full");

  // Remove on empty reports an empty queue
  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STATUS_EMPTY |-> occupancy_i == '0)
    else $error("empty status with entries queued");

  // Failed commands return no identifier
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != STATUS_OK |-> thread_out_i == '0)
    else $error("identifier returned on failed command");

endmodule

bind wait_queue_with_cancel_top wqc_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_wqc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .status_i     (out_ch.status),
  .thread_out_i (out_ch.thread_out),
  .occupancy_i  (out_ch.occupancy)
);

// ===== tb/tb.sv =====
// Testbench for wait_queue_with_cancel_top: directed and random command traffic with
// random idling on both channels, checked against a shadow queue kept in the bench.
// Depends on wqc_pkg, wqc_if and the top level of the block.
module tb import wqc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned ID_WIDTH    = 16;
  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;    // unused code, block treats it as no-op
  localparam logic [TID_W-1:0] ID_MASK = TID_W'((64'd1 << ID_WIDTH) - 1);
  localparam int unsigned DRAIN_CYCLES = QUEUE_DEPTH + 4;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TID_W-1:0]    thread_out;
    logic [OCC_W-1:0]    occupancy;
  } queue_result_t;

  logic clk_i;
  logic rst_ni;

  wqc_in_if  in_ch ();
  wqc_out_if out_ch ();

  wait_queue_with_cancel_top #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .ID_WIDTH   (ID_WIDTH)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // Shadow of the queue contents, head at index 0
  logic [TID_W-1:0] shadow_queue[$];
  queue_result_t    pending_results[$];

  int unsigned error_count   = 0;
  int unsigned idle_cycles   = 0;
  int unsigned tx_idle_pct   = 0;
  int unsigned rx_idle_pct   = 0;
  int unsigned rx_hold_left  = 0;
  int unsigned rx_stall_left = 0;

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Apply one command to the shadow queue and return the result it must give
  function automatic queue_result_t queue_after_command(input logic [CMD_W-1:0] cmd,
                                                        input logic [TID_W-1:0] tid);
    queue_result_t    res;
    logic [TID_W-1:0] survivors[$];
    logic [TID_W-1:0] key;
    res = '0;
    key = tid & ID_MASK;
    case (cmd)
      CMD_ADD: begin
        if (shadow_queue.size() >= QUEUE_DEPTH) res.status = STATUS_FULL;
        else shadow_queue.push_back(key);
      end
      CMD_REMOVE: begin
        if (shadow_queue.size() == 0) res.status = STATUS_EMPTY;
        else res.thread_out = shadow_queue.pop_front();
      end
      CMD_CANCEL: begin
        foreach (shadow_queue[i]) if (shadow_queue[i] != key) survivors.push_back(shadow_queue[i]);
        shadow_queue = survivors;
      end
      default: ;
    endcase
    res.occupancy = OCC_W'(shadow_queue.size());
    return res;
  endfunction

  // Idle length: mostly short, now and then long
  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void flag_error(input string what, input int unsigned want,
                                     input int unsigned got);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("tb: mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
  endfunction

  // Offer one command, hold it until the transfer, then record its expected result
  task automatic issue_command(input logic [CMD_W-1:0] cmd, input logic [TID_W-1:0] tid);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < tx_idle_pct) gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.thread_id <= tid;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_results.push_back(queue_after_command(cmd, tid));
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Result side: random stalls, plus a long hold-off when a test asks for one
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_left > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_left--;
      end else if (rx_stall_left > 0) begin
        out_ch.ready <= 1'b0;
        rx_stall_left--;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        out_ch.ready <= 1'b0;
        rx_stall_left = pick_gap() - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    queue_result_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        flag_error("result with nothing pending, status", 0, out_ch.status);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.status !== want.status)
          flag_error("status", want.status, out_ch.status);
        if (out_ch.thread_out !== want.thread_out)
          flag_error("thread_out", want.thread_out, out_ch.thread_out);
        if (out_ch.occupancy !== want.occupancy)
          flag_error("occupancy", want.occupancy, out_ch.occupancy);
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Remove, cancel and an unused code on an empty queue
  task automatic test_empty_queue();
    issue_command(CMD_REMOVE, 16'hFFFF);
    issue_command(CMD_CANCEL, 16'h0000);
    issue_command(CMD_NOP,    16'hFFFF);
  endtask

  // Fill to the brim, overflow, cancel duplicates and a missing id, pop a few
  task automatic test_fill_overflow_cancel();
    logic [TID_W-1:0] tid;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      case (i)
        0:       tid = 16'h0000;
        2:       tid = 16'hA5A5;
        4:       tid = 16'h5A5A;
        1, 3, 15: tid = 16'hFFFF;
        default: tid = 16'h0F00 + TID_W'(i);
      endcase
      issue_command(CMD_ADD, tid);
    end
    issue_command(CMD_ADD,    16'hBEEF);
    issue_command(CMD_CANCEL, 16'hFFFF);
    issue_command(CMD_CANCEL, 16'h1234);
    issue_command(CMD_REMOVE, 16'h0000);
    issue_command(CMD_REMOVE, 16'hFFFF);
    wait_drained();
  endtask

  // Hold the result side off while commands keep coming, so the block stalls its input
  task automatic test_back_pressure();
    tx_idle_pct  = 0;
    rx_hold_left = 200;
    for (int i = 0; i < 30; i++) begin
      if (i % 5 == 4) issue_command(CMD_CANCEL, TID_W'($urandom_range(0, 3)));
      else if (i % 7 == 6) issue_command(CMD_REMOVE, TID_W'($urandom));
      else issue_command(CMD_ADD, TID_W'($urandom_range(0, 3)));
    end
    wait_drained();
  endtask

  // Random commands over a small id pool so cancels hit often
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned add_pct,
                                     input int unsigned remove_pct, input int unsigned cancel_pct,
                                     input int unsigned tx_pct, input int unsigned rx_pct);
    logic [TID_W-1:0] id_pool[4];
    logic [CMD_W-1:0] cmd;
    logic [TID_W-1:0] tid;
    int unsigned      pick;
    foreach (id_pool[i]) id_pool[i] = TID_W'($urandom);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < add_pct) cmd = CMD_ADD;
      else if (pick < add_pct + remove_pct) cmd = CMD_REMOVE;
      else if (pick < add_pct + remove_pct + cancel_pct) cmd = CMD_CANCEL;
      else cmd = CMD_NOP;
      if ($urandom_range(0, 99) < 80) tid = id_pool[$urandom_range(0, 3)];
      else tid = TID_W'($urandom);
      issue_command(cmd, tid);
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.cmd       = CMD_ADD;
    in_ch.thread_id = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_fill_overflow_cancel();
    test_back_pressure();

    test_random_traffic(50, 45, 30, 22, 30, 30);
    test_random_traffic(50, 75, 12, 10,  0,  0);
    test_random_traffic(50, 20, 65, 12, 50, 50);
    wait_drained();
    test_random_traffic(50, 50, 13, 35, 20, 60);
    test_random_traffic(50, 80,  5, 12, 10, 10);
    test_random_traffic(50, 40, 40, 17,  0, 40);
    wait_drained();
    test_random_traffic(50, 55, 15, 27, 60, 10);
    test_random_traffic(50, 25, 50, 22, 40,  0);
    test_random_traffic(50, 60, 25, 12, 15, 15);
    test_random_traffic(50, 45, 30, 20, 35, 35);

    // Let any stray result show up before the verdict
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
